[rtl/i2crrs_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register read sequencer package
// Shared types and codes for the event, result and sequencer state.
// ----------------------------------------------------------------------------
package i2crrs_pkg;

  localparam int unsigned BYTE_BITS = 8;

  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_ACK   = 3'd1;
  localparam logic [2:0] KIND_NACK  = 3'd2;
  localparam logic [2:0] KIND_RXDV  = 3'd3;
  localparam logic [2:0] KIND_MSTOP = 3'd4;

  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_ADDR_W = 7'b0000010,
    PH_REG    = 7'b0000100,
    PH_ADDR_R = 7'b0001000,
    PH_MSB    = 7'b0010000,
    PH_LSB    = 7'b0100000,
    PH_END    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] dev_addr;
    logic [7:0] reg_byte;
    logic [7:0] rx_byte;
  } ev_item_t;

  typedef struct packed {
    logic        cmd_start;
    logic        cmd_ack;
    logic        cmd_nack;
    logic        cmd_stop;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [15:0] read_value;
    logic        done_res;
    logic        protocol_error;
  } res_item_t;

  typedef struct packed {
    phase_t      phase;
    logic [6:0]  target_address;
    logic [7:0]  command_byte;
    logic [15:0] value_register;
  } seq_state_t;

endpackage

[rtl/i2crrs_step.sv]
// ----------------------------------------------------------------------------
// I2C register read sequencer step
// Computes the next sequencer state and the result for one bus event.
// ----------------------------------------------------------------------------
module i2crrs_step
  import i2crrs_pkg::*;
(
  input  seq_state_t st,
  input  ev_item_t   ev,
  output seq_state_t st_next,
  output res_item_t  res
);

  logic       ok;
  logic [7:0] addr_rd;

  assign addr_rd = {st.target_address, RW_READ};

  always_comb begin
    st_next = st;
    res     = '0;
    ok      = 1'b0;
    unique case (ev.kind)
      KIND_START: begin
        if (st.phase == PH_IDLE || st.phase == PH_END) begin
          st_next.target_address = ev.dev_addr;
          st_next.command_byte   = ev.reg_byte;
          st_next.phase          = PH_ADDR_W;
          res.cmd_start          = 1'b1;
          res.tx_valid           = 1'b1;
          res.tx_byte            = {ev.dev_addr, RW_WRITE};
          ok                     = 1'b1;
        end
      end
      KIND_ACK: begin
        priority if (st.phase == PH_ADDR_W) begin
          st_next.phase = PH_REG;
          res.tx_valid  = 1'b1;
          res.tx_byte   = st.command_byte;
          ok            = 1'b1;
        end else if (st.phase == PH_REG) begin
          st_next.phase = PH_ADDR_R;
          res.cmd_start = 1'b1;
          res.tx_valid  = 1'b1;
          res.tx_byte   = addr_rd;
          ok            = 1'b1;
        end else if (st.phase == PH_ADDR_R) begin
          st_next.phase = PH_MSB;
          ok            = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      KIND_NACK: begin
        if (st.phase == PH_ADDR_R) begin
          res.cmd_start = 1'b1;
          res.tx_valid  = 1'b1;
          res.tx_byte   = addr_rd;
          ok            = 1'b1;
        end
      end
      KIND_RXDV: begin
        priority if (st.phase == PH_MSB) begin
          st_next.value_register = {ev.rx_byte, {BYTE_BITS{1'b0}}};
          st_next.phase          = PH_LSB;
          res.cmd_ack            = 1'b1;
          ok                     = 1'b1;
        end else if (st.phase == PH_LSB) begin
          st_next.value_register = st.value_register | {{BYTE_BITS{1'b0}}, ev.rx_byte};
          st_next.phase          = PH_END;
          res.cmd_nack           = 1'b1;
          res.cmd_stop           = 1'b1;
          ok                     = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      KIND_MSTOP: begin
        if (st.phase == PH_END) begin
          res.done_res = 1'b1;
          ok           = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!ok) begin
      st_next            = st;
      res                = '0;
      res.protocol_error = 1'b1;
    end
    res.read_value = st_next.value_register;
  end

endmodule

[rtl/i2crrs_pipe.sv]
// ----------------------------------------------------------------------------
// I2C register read sequencer pipeline
// Input register, sequencer state registers and result register with stall.
// ----------------------------------------------------------------------------
module i2crrs_pipe
  import i2crrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      ev_valid,
  output logic      ev_stall,
  input  ev_item_t  ev,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  logic       hold_valid;
  ev_item_t   hold;
  seq_state_t st;
  seq_state_t st_next;
  res_item_t  step_res;
  logic       res_free;
  logic       step_fire;

  assign res_free  = !res_valid || !res_stall;
  assign step_fire = hold_valid && res_free;
  assign ev_stall  = hold_valid && !res_free;

  i2crrs_step u_step (
    .st      (st),
    .ev      (hold),
    .st_next (st_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!ev_stall) begin
      hold_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && !ev_stall) begin
      hold <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_IDLE;
      st.target_address <= '0;
      st.command_byte   <= '0;
      st.value_register <= '0;
    end else if (step_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res <= step_res;
    end
  end

`ifndef SYNTHESIS
  a_error_keeps_state: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_res.protocol_error |=> $stable(st))
    else $error("Rejected event changed the sequencer state.");

  a_done_in_end: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_res.done_res |=> st.phase == PH_END)
    else $error("Completion reported outside the end phase.");

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (rst)
    ev_stall |-> hold_valid && res_valid)
    else $error("Event stalled with a free pipeline.");

  a_start_sends_addr: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.cmd_start |-> res.tx_valid && !res.protocol_error)
    else $error("Start issued without an address byte.");
`endif

endmodule

[rtl/i2c_register_read_sequencer_top.sv]
// ----------------------------------------------------------------------------
// I2C register read sequencer
// Sequences an I2C master read of one 16-bit register from bus events.
// ----------------------------------------------------------------------------
// Usage: the event channel (ev_valid, ev_stall, ev) carries one bus event per
// transfer: start, ack, nack, received byte or master stop. The result channel
// (res_valid, res_stall, res) returns exactly one result per event with the
// bus commands to issue, the byte to send, the assembled read value and the
// done and protocol error flags.
// An event is registered in the input register at its transfer, processed
// by the combinational step, and its result is registered in the result
// register. Throughput is one event per cycle while the result is not
// stalled, set by the combinational phase update between the registers.
// Reset clears both valid flags, returns the sequencer to idle and clears the
// stored addresses and read value.
// When the receiver stalls, the result holds; the input register still takes
// one more event, and then ev_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module i2c_register_read_sequencer_top
  import i2crrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      ev_valid,
  output logic      ev_stall,
  input  ev_item_t  ev,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  i2crrs_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (ev_valid),
    .ev_stall  (ev_stall),
    .ev        (ev),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
